// File: sv/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define MPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define MPA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/mpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiprecision ALU package
// Widths, command and order codes, item and job types shared by the block.
// ----------------------------------------------------------------------------
package mpa_pkg;

    localparam int MAX_BYTES = 32;
    localparam int BYTE_W    = 8;
    localparam int OPW       = MAX_BYTES * BYTE_W;
    localparam int CHUNK_W   = 32;
    localparam int CHUNKS    = (OPW + 1 + CHUNK_W - 1) / CHUNK_W;
    localparam int RW        = CHUNKS * CHUNK_W;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int CHK_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int BIT_W     = $clog2(OPW + 1);
    localparam int PROD_W    = BYTE_W + CHUNK_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int CARRY_W   = ACC_W - CHUNK_W;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;

    localparam logic [1:0] ORD_EQ = 2'd0;
    localparam logic [1:0] ORD_GT = 2'd1;
    localparam logic [1:0] ORD_LT = 2'd2;

    typedef struct packed {
        logic [2:0]        command;
        logic [BYTE_W-1:0] a_byte;
        logic [BYTE_W-1:0] b_byte;
        logic              last;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic [BYTE_W-1:0] remainder_byte;
        logic [1:0]        order;
        logic              divide_by_zero;
        logic              too_long;
        logic              last_out;
    } t_out_item;

    // One closed operation: operands are top aligned, byte 0 at MAX_BYTES-count.
    typedef struct packed {
        logic [2:0]       command;
        logic [CNT_W-1:0] count;
        logic             too_long;
        logic [OPW-1:0]   a;
        logic [OPW-1:0]   b;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_ADDSUB,
        ST_MUL_PROD,
        ST_MUL_ACC,
        ST_DIV_SHIFT,
        ST_DIV_SUB,
        ST_DIV_COMMIT,
        ST_EMIT
    } t_state;

endpackage

// File: sv/mpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiprecision ALU front end
// Collects operand byte pairs and hands each closed operation to the job queue.
// ----------------------------------------------------------------------------
module mpa_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mpa_pkg::t_in_item  i_in_item,
    input  logic               i_q_full,
    output logic               o_job_push,
    output mpa_pkg::t_job      o_job
);

    logic [mpa_pkg::OPW-1:0]   r_a, n_a;
    logic [mpa_pkg::OPW-1:0]   r_b, n_b;
    logic [mpa_pkg::CNT_W-1:0] r_count, n_count, w_count;
    logic                      r_ovf, n_ovf, w_ovf;
    logic                      w_transfer;

    always_comb begin
        w_transfer = i_push & ~i_q_full;
        n_a     = r_a;
        n_b     = r_b;
        w_count = r_count;
        w_ovf   = r_ovf;
        if (w_transfer) begin
            if (r_count < mpa_pkg::CNT_W'(mpa_pkg::MAX_BYTES)) begin
                n_a     = {i_in_item.a_byte, r_a[mpa_pkg::OPW-1:mpa_pkg::BYTE_W]};
                n_b     = {i_in_item.b_byte, r_b[mpa_pkg::OPW-1:mpa_pkg::BYTE_W]};
                w_count = r_count + 1'b1;
            end else begin
                w_ovf = 1'b1;
            end
        end
        o_job_push       = w_transfer & i_in_item.last;
        o_job.command    = i_in_item.command;
        o_job.count      = w_count;
        o_job.too_long   = w_ovf;
        o_job.a          = n_a;
        o_job.b          = n_b;
        n_count = o_job_push ? '0 : w_count;
        n_ovf   = o_job_push ? 1'b0 : w_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // Stale bytes below the current operand are shifted out or ignored by the back end.
    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
    end

endmodule

// File: sv/mpa_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiprecision ALU job queue
// Two-entry queue of closed operations between front and back end.
// ----------------------------------------------------------------------------
module mpa_job_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mpa_pkg::t_job       i_job,
    input  logic                i_pop,
    output mpa_pkg::t_job       o_job,
    output mpa_pkg::t_q_status  o_status
);

    mpa_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt, n_cnt;

    always_comb begin
        o_status.full  = (r_cnt == 2'd2);
        o_status.empty = (r_cnt == 2'd0);
        o_job          = r_mem[r_rp];
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// File: sv/mpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiprecision ALU back end
// Runs one operation at a time over 32-bit chunks and streams the result bytes.
// ----------------------------------------------------------------------------
module mpa_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  mpa_pkg::t_job      i_job,
    output logic               o_job_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output mpa_pkg::t_out_item o_out_item
);

    mpa_pkg::t_state             r_state, n_state;
    logic [2:0]                  r_cmd;
    logic [mpa_pkg::CNT_W-1:0]   r_n, r_round, r_emit, w_emit_total;
    logic                        r_tl, r_dz;
    logic [mpa_pkg::OPW-1:0]     r_a, r_b;
    logic [mpa_pkg::RW-1:0]      r_m, r_q, r_r, r_d, w_a_ext, w_b_ext;
    logic [mpa_pkg::BIT_W-1:0]   r_cnt;
    logic [mpa_pkg::CHK_W-1:0]   r_chunk;
    logic [mpa_pkg::CARRY_W-1:0] r_carry;
    logic [mpa_pkg::PROD_W-1:0]  r_prod;
    logic [1:0]                  r_order;
    logic                        r_out_valid;
    mpa_pkg::t_out_item          r_out;
    logic [mpa_pkg::CHUNK_W-1:0] w_x, w_y, w_qc, w_rc, w_mc;
    logic [mpa_pkg::CHUNK_W:0]   w_sum, w_diff, w_dsub;
    logic [mpa_pkg::ACC_W-1:0]   w_macc;
    logic                        w_last_chunk, w_out_free, w_emit_last;
    logic                        w_align_done, w_b_zero, w_load_out;

    always_comb begin
        w_a_ext = {{(mpa_pkg::RW-mpa_pkg::OPW){1'b0}}, r_a};
        w_b_ext = {{(mpa_pkg::RW-mpa_pkg::OPW){1'b0}}, r_b};
        w_x  = w_a_ext[r_chunk*mpa_pkg::CHUNK_W +: mpa_pkg::CHUNK_W];
        w_y  = w_b_ext[r_chunk*mpa_pkg::CHUNK_W +: mpa_pkg::CHUNK_W];
        w_qc = r_q[r_chunk*mpa_pkg::CHUNK_W +: mpa_pkg::CHUNK_W];
        w_rc = r_r[r_chunk*mpa_pkg::CHUNK_W +: mpa_pkg::CHUNK_W];
        w_mc = r_m[r_chunk*mpa_pkg::CHUNK_W +: mpa_pkg::CHUNK_W];
        w_sum  = {1'b0, w_x} + {1'b0, w_y} + (mpa_pkg::CHUNK_W+1)'(r_carry[0]);
        w_diff = {1'b0, w_x} - {1'b0, w_y} - (mpa_pkg::CHUNK_W+1)'(r_carry[0]);
        w_dsub = {1'b0, w_rc} - {1'b0, w_y} - (mpa_pkg::CHUNK_W+1)'(r_carry[0]);
        w_macc = mpa_pkg::ACC_W'(w_qc) + mpa_pkg::ACC_W'(r_prod)
               + mpa_pkg::ACC_W'(r_carry);
        w_last_chunk = (r_chunk == mpa_pkg::CHK_W'(mpa_pkg::CHUNKS - 1));
        w_out_free   = ~r_out_valid | i_pop;
        w_emit_total = (r_cmd == mpa_pkg::CMD_CMP) ? mpa_pkg::CNT_W'(1) : r_n;
        w_emit_last  = ((r_emit + 1'b1) == w_emit_total);
        w_align_done = (r_cnt == mpa_pkg::BIT_W'(mpa_pkg::MAX_BYTES));
        w_b_zero     = (r_b == '0);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mpa_pkg::ST_IDLE: begin
                if (!i_q_empty) n_state = mpa_pkg::ST_ALIGN;
            end
            mpa_pkg::ST_ALIGN: begin
                if (w_align_done) begin
                    case (r_cmd)
                        mpa_pkg::CMD_MUL: n_state = mpa_pkg::ST_MUL_PROD;
                        mpa_pkg::CMD_DIV: begin
                            n_state = w_b_zero ? mpa_pkg::ST_EMIT : mpa_pkg::ST_DIV_SHIFT;
                        end
                        default: n_state = mpa_pkg::ST_ADDSUB;
                    endcase
                end
            end
            mpa_pkg::ST_ADDSUB: begin
                if (w_last_chunk) n_state = mpa_pkg::ST_EMIT;
            end
            mpa_pkg::ST_MUL_PROD: n_state = mpa_pkg::ST_MUL_ACC;
            mpa_pkg::ST_MUL_ACC: begin
                if (w_last_chunk && (r_round + 1'b1) == r_n) begin
                    n_state = mpa_pkg::ST_EMIT;
                end else begin
                    n_state = mpa_pkg::ST_MUL_PROD;
                end
            end
            mpa_pkg::ST_DIV_SHIFT: n_state = mpa_pkg::ST_DIV_SUB;
            mpa_pkg::ST_DIV_SUB: begin
                if (w_last_chunk) n_state = mpa_pkg::ST_DIV_COMMIT;
            end
            mpa_pkg::ST_DIV_COMMIT: begin
                n_state = (r_cnt == mpa_pkg::BIT_W'(1)) ? mpa_pkg::ST_EMIT
                                                        : mpa_pkg::ST_DIV_SHIFT;
            end
            mpa_pkg::ST_EMIT: begin
                if (w_out_free && w_emit_last) n_state = mpa_pkg::ST_IDLE;
            end
            default: n_state = mpa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop  = (r_state == mpa_pkg::ST_IDLE) & ~i_q_empty;
        w_load_out = (r_state == mpa_pkg::ST_EMIT) & w_out_free;
        o_empty    = ~r_out_valid;
        o_out_item = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mpa_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            mpa_pkg::ST_IDLE: begin
                if (o_job_pop) begin
                    r_cmd   <= i_job.command;
                    r_n     <= i_job.count;
                    r_tl    <= i_job.too_long;
                    r_a     <= i_job.a;
                    r_b     <= i_job.b;
                    r_cnt   <= mpa_pkg::BIT_W'(i_job.count);
                    r_q     <= '0;
                    r_r     <= '0;
                    r_order <= mpa_pkg::ORD_EQ;
                    r_dz    <= 1'b0;
                    r_carry <= '0;
                    r_chunk <= '0;
                    r_round <= '0;
                    r_emit  <= '0;
                end
            end
            mpa_pkg::ST_ALIGN: begin
                // Divide keeps A at the top so its bits leave from the MSB.
                if (!w_align_done) begin
                    r_b <= r_b >> mpa_pkg::BYTE_W;
                    if (r_cmd != mpa_pkg::CMD_DIV) begin
                        r_a <= r_a >> mpa_pkg::BYTE_W;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_m   <= w_b_ext;
                    r_cnt <= mpa_pkg::BIT_W'({r_n, 3'b000});
                    if (r_cmd == mpa_pkg::CMD_DIV && w_b_zero) begin
                        r_dz <= 1'b1;
                    end
                end
            end
            mpa_pkg::ST_ADDSUB: begin
                case (r_cmd)
                    mpa_pkg::CMD_ADD: begin
                        r_q[r_chunk*mpa_pkg::CHUNK_W +: mpa_pkg::CHUNK_W] <=
                            w_sum[mpa_pkg::CHUNK_W-1:0];
                        r_carry <= mpa_pkg::CARRY_W'(w_sum[mpa_pkg::CHUNK_W]);
                    end
                    mpa_pkg::CMD_SUB: begin
                        r_q[r_chunk*mpa_pkg::CHUNK_W +: mpa_pkg::CHUNK_W] <=
                            w_diff[mpa_pkg::CHUNK_W-1:0];
                        r_carry <= mpa_pkg::CARRY_W'(w_diff[mpa_pkg::CHUNK_W]);
                    end
                    mpa_pkg::CMD_CMP: begin
                        // The highest differing chunk is the last to write.
                        if (w_x != w_y) begin
                            r_order <= (w_x > w_y) ? mpa_pkg::ORD_GT : mpa_pkg::ORD_LT;
                        end
                    end
                    default: begin
                    end
                endcase
                r_chunk <= r_chunk + 1'b1;
            end
            mpa_pkg::ST_MUL_PROD: begin
                r_prod <= r_a[mpa_pkg::BYTE_W-1:0] * w_mc;
            end
            mpa_pkg::ST_MUL_ACC: begin
                r_q[r_chunk*mpa_pkg::CHUNK_W +: mpa_pkg::CHUNK_W] <=
                    w_macc[mpa_pkg::CHUNK_W-1:0];
                if (w_last_chunk) begin
                    r_chunk <= '0;
                    r_carry <= '0;
                    r_a     <= r_a >> mpa_pkg::BYTE_W;
                    r_m     <= r_m << mpa_pkg::BYTE_W;
                    r_round <= r_round + 1'b1;
                end else begin
                    r_chunk <= r_chunk + 1'b1;
                    r_carry <= w_macc[mpa_pkg::ACC_W-1:mpa_pkg::CHUNK_W];
                end
            end
            mpa_pkg::ST_DIV_SHIFT: begin
                r_r     <= {r_r[mpa_pkg::RW-2:0], r_a[mpa_pkg::OPW-1]};
                r_a     <= r_a << 1;
                r_chunk <= '0;
                r_carry <= '0;
            end
            mpa_pkg::ST_DIV_SUB: begin
                r_d[r_chunk*mpa_pkg::CHUNK_W +: mpa_pkg::CHUNK_W] <=
                    w_dsub[mpa_pkg::CHUNK_W-1:0];
                r_carry <= mpa_pkg::CARRY_W'(w_dsub[mpa_pkg::CHUNK_W]);
                r_chunk <= r_chunk + 1'b1;
            end
            mpa_pkg::ST_DIV_COMMIT: begin
                // No final borrow means the trial difference is kept.
                if (!r_carry[0]) begin
                    r_r <= r_d;
                end
                r_q   <= {r_q[mpa_pkg::RW-2:0], ~r_carry[0]};
                r_cnt <= r_cnt - 1'b1;
            end
            mpa_pkg::ST_EMIT: begin
                if (w_load_out) begin
                    r_out.result_byte    <= r_q[mpa_pkg::BYTE_W-1:0];
                    r_out.remainder_byte <= r_r[mpa_pkg::BYTE_W-1:0];
                    r_out.order          <= r_order;
                    r_out.divide_by_zero <= r_dz;
                    r_out.too_long       <= r_tl;
                    r_out.last_out       <= w_emit_last;
                    r_q    <= r_q >> mpa_pkg::BYTE_W;
                    r_r    <= r_r >> mpa_pkg::BYTE_W;
                    r_emit <= r_emit + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: sv/multiprecision_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiprecision ALU
// Unsigned add, subtract, multiply, divide and compare on byte-serial operands.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// input     in         push / full           i_in_item  (mpa_pkg::t_in_item)
// result    out        empty / pop           o_out_item (mpa_pkg::t_out_item)
//
// One operand byte pair per cycle; a closed operation waits in a two-entry
// job queue, so the next operation loads while the back end works.
// Back end, n bytes, C = 9 chunks of 32 bits: alignment, then add, subtract
// or compare chunk by chunk, multiply byte by chunk, divide bit by bit, then
// one result byte per cycle while results are popped. It uses a chunk adder
// and an 8x32 multiplier. Reset is synchronous and leaves the block ready at once.
// A stalled result holds the back end; the front end stalls only when the
// job queue holds two operations.
`include "assert_macros.svh"

module multiprecision_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  mpa_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output mpa_pkg::t_out_item o_out_item
);

    logic               w_job_push, w_job_pop;
    mpa_pkg::t_job      w_job_in, w_job_out;
    mpa_pkg::t_q_status w_q_status;

    assign full = w_q_status.full;

    mpa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in_item  (i_in_item),
        .i_q_full   (w_q_status.full),
        .o_job_push (w_job_push),
        .o_job      (w_job_in)
    );

    mpa_job_fifo u_job_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_job_push),
        .i_job    (w_job_in),
        .i_pop    (w_job_pop),
        .o_job    (w_job_out),
        .o_status (w_q_status)
    );

    mpa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_status.empty),
        .i_job      (w_job_out),
        .o_job_pop  (w_job_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_item (o_out_item)
    );

    `MPA_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> empty, "result pending after reset")
    `MPA_ASSERT(a_dz_zero, i_clk, i_rst_n, !empty && o_out_item.divide_by_zero |-> o_out_item.result_byte == 8'd0 && o_out_item.remainder_byte == 8'd0, "nonzero bytes on divide by zero")
    `MPA_ASSERT(a_cmp_single, i_clk, i_rst_n, !empty && o_out_item.order != mpa_pkg::ORD_EQ |-> o_out_item.last_out && o_out_item.result_byte == 8'd0, "compare result not a single final transfer")
    `MPA_ASSERT(a_queue_flags, i_clk, i_rst_n, !(w_q_status.full && w_q_status.empty), "job queue both full and empty")

endmodule

// File: test/tb_multiprecision_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiprecision ALU testbench
// Streams byte-serial operands for every command through the block, predicts
// each result byte with an independent bignum model and checks every transfer.
// ----------------------------------------------------------------------------
module tb_multiprecision_alu;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 3000;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    mpa_pkg::t_in_item  i_in_item;
    logic               empty;
    logic               pop;
    mpa_pkg::t_out_item o_out_item;

    multiprecision_alu u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    // Operand bytes gathered so far for the open operation.
    logic [mpa_pkg::OPW-1:0] acc_a;
    logic [mpa_pkg::OPW-1:0] acc_b;
    int                      stored_bytes;
    logic                    overflowed;

    mpa_pkg::t_out_item expected_bytes[$];
    int                 error_count;
    int                 idle_cycles;
    bit                 stall_enable;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        if (!stall_enable) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Works out the results of the operation closed by a last byte pair.
    task automatic predict_operation(input logic [2:0] cmd);
        logic [mpa_pkg::OPW-1:0]   mask;
        logic [mpa_pkg::OPW-1:0]   x;
        logic [mpa_pkg::OPW-1:0]   y;
        logic [mpa_pkg::OPW-1:0]   quotient;
        logic [mpa_pkg::OPW-1:0]   rest;
        logic [2*mpa_pkg::OPW-1:0] product;
        mpa_pkg::t_out_item        item;
        int                        count;
        logic                      div_zero;
        logic [1:0]                ord;
        mask = (stored_bytes == mpa_pkg::MAX_BYTES) ? '1
             : ((mpa_pkg::OPW'(1) << (8 * stored_bytes)) - 1);
        x = acc_a & mask;
        y = acc_b & mask;
        quotient = '0;
        rest = '0;
        div_zero = 1'b0;
        ord = mpa_pkg::ORD_EQ;
        count = (cmd == mpa_pkg::CMD_CMP) ? 1 : stored_bytes;
        case (cmd)
            mpa_pkg::CMD_ADD: quotient = (x + y) & mask;
            mpa_pkg::CMD_SUB: quotient = (x - y) & mask;
            mpa_pkg::CMD_MUL: begin
                product = x * y;
                quotient = product[mpa_pkg::OPW-1:0] & mask;
            end
            mpa_pkg::CMD_DIV: begin
                if (y == '0) begin
                    div_zero = 1'b1;
                end else begin
                    quotient = x / y;
                    rest = x % y;
                end
            end
            mpa_pkg::CMD_CMP: begin
                ord = (x > y) ? mpa_pkg::ORD_GT
                    : ((x < y) ? mpa_pkg::ORD_LT : mpa_pkg::ORD_EQ);
            end
            default: quotient = '0;
        endcase
        for (int k = 0; k < count; k++) begin
            item.result_byte    = quotient[8*k +: 8];
            item.remainder_byte = (cmd == mpa_pkg::CMD_DIV) ? rest[8*k +: 8] : 8'd0;
            item.order          = ord;
            item.divide_by_zero = div_zero;
            item.too_long       = overflowed;
            item.last_out       = (k == count - 1);
            expected_bytes.push_back(item);
        end
        stored_bytes = 0;
        overflowed = 1'b0;
        acc_a = '0;
        acc_b = '0;
    endtask

    task automatic send_pair(input logic [2:0] cmd, input logic [7:0] a, input logic [7:0] b,
                             input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in_item <= '{command: cmd, a_byte: a, b_byte: b, last: last};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (stored_bytes < mpa_pkg::MAX_BYTES) begin
            acc_a[8*stored_bytes +: 8] = a;
            acc_b[8*stored_bytes +: 8] = b;
            stored_bytes++;
        end else begin
            overflowed = 1'b1;
        end
        if (last) predict_operation(cmd);
    endtask

    // Sends an operation of n byte pairs; pattern 0 random, 1 all zero, 2 all ones,
    // 3 equal operands, 4 divisor zero, 5 divisor often small.
    task automatic send_operation(input logic [2:0] cmd, input int n, input int pattern);
        logic [7:0] a;
        logic [7:0] b;
        for (int k = 0; k < n; k++) begin
            a = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
            case (pattern)
                1: begin a = 8'h00; b = 8'h00; end
                2: begin a = 8'hff; b = 8'hff; end
                3: b = a;
                4: b = 8'h00;
                5: if ($urandom_range(0, 1)) b = (k == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                default: ;
            endcase
            // Other commands on non-final pairs must be ignored.
            send_pair((k == n - 1) ? cmd : 3'($urandom_range(0, 7)), a, b, k == n - 1);
        end
    endtask

    task automatic test_directed();
        send_operation(mpa_pkg::CMD_ADD, 1, 2);
        send_operation(mpa_pkg::CMD_SUB, 1, 1);
        send_operation(mpa_pkg::CMD_SUB, 2, 0);
        send_operation(mpa_pkg::CMD_MUL, 2, 2);
        send_operation(mpa_pkg::CMD_DIV, 2, 0);
        send_operation(mpa_pkg::CMD_DIV, 2, 4);
        send_operation(mpa_pkg::CMD_CMP, 1, 3);
        send_operation(mpa_pkg::CMD_CMP, 2, 0);
        send_operation(3'd5, 1, 0);
        send_operation(3'd7, 1, 0);
        send_operation(mpa_pkg::CMD_DIV, 3, 5);
    endtask

    task automatic test_long_operands();
        send_operation(mpa_pkg::CMD_DIV, mpa_pkg::MAX_BYTES, 0);
        send_operation(mpa_pkg::CMD_ADD, mpa_pkg::MAX_BYTES + 1, 0);
    endtask

    task automatic test_random();
        int n;
        for (int op = 0; op < 5; op++) begin
            n = $urandom_range(1, 4);
            send_operation(3'($urandom_range(0, 7)), n, $urandom_range(0, 5));
        end
    endtask

    task automatic test_back_to_back();
        stall_enable = 1'b0;
        for (int op = 0; op < 4; op++) send_operation(3'($urandom_range(0, 4)), 2, 0);
        stall_enable = 1'b1;
    endtask

    // Result side: random pop pattern and checking of each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected result transfer");
                    error_count++;
                end else begin
                    mpa_pkg::t_out_item want;
                    want = expected_bytes.pop_front();
                    if (o_out_item.result_byte !== want.result_byte) begin
                        $error("result_byte expected %0h actual %0h",
                               want.result_byte, o_out_item.result_byte);
                        error_count++;
                    end
                    if (o_out_item.remainder_byte !== want.remainder_byte) begin
                        $error("remainder_byte expected %0h actual %0h",
                               want.remainder_byte, o_out_item.remainder_byte);
                        error_count++;
                    end
                    if (o_out_item.order !== want.order) begin
                        $error("order expected %0d actual %0d", want.order, o_out_item.order);
                        error_count++;
                    end
                    if (o_out_item.divide_by_zero !== want.divide_by_zero) begin
                        $error("divide_by_zero expected %0b actual %0b",
                               want.divide_by_zero, o_out_item.divide_by_zero);
                        error_count++;
                    end
                    if (o_out_item.too_long !== want.too_long) begin
                        $error("too_long expected %0b actual %0b",
                               want.too_long, o_out_item.too_long);
                        error_count++;
                    end
                    if (o_out_item.last_out !== want.last_out) begin
                        $error("last_out expected %0b actual %0b",
                               want.last_out, o_out_item.last_out);
                        error_count++;
                    end
                end
            end
            if (!stall_enable) pop <= 1'b1;
            else if ($urandom_range(0, 19) == 0) pop <= 1'b0;
            else if ($urandom_range(0, 3) == 0) pop <= ($urandom_range(0, 1) == 1);
            else if ($urandom_range(0, 29) == 0) pop <= 1'b0;
            else pop <= 1'b1;
        end
    end

    // Watchdog: counts cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int waited;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_in_item = '0;
        error_count = 0;
        idle_cycles = 0;
        stall_enable = 1'b1;
        stored_bytes = 0;
        overflowed = 1'b0;
        acc_a = '0;
        acc_b = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_long_operands();
        test_back_to_back();
        test_random();
        push <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        waited = 0;
        while (waited < DRAIN_CYCLES) begin
            @(posedge i_clk);
            waited++;
        end
        if (error_count == 0 && expected_bytes.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+sv
sv/mpa_pkg.sv
sv/mpa_front.sv
sv/mpa_job_fifo.sv
sv/mpa_back.sv
sv/multiprecision_alu.sv
test/tb_multiprecision_alu.sv
